// File: hw/rtl/hsv_xf_pkg.sv
// package: shared types, field widths and reset values for the hsv hold and crossfade block
`default_nettype none
package hsv_xf_pkg;

    localparam int TIME_BITS_DEF = 16;

    localparam int ELAPSED_W = 10;
    localparam int COLOR_W   = 8;
    localparam int CFG_TIME_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int PROD_W    = COLOR_W + CFG_TIME_W;

    localparam logic [CFG_TIME_W-1:0] HOLD_TIME_RST = 16'd5000;
    localparam logic [CFG_TIME_W-1:0] MOVE_TIME_RST = 16'd5000;
    localparam logic [COLOR_W-1:0]    SAT_RST       = 8'd255;
    localparam logic [COLOR_W-1:0]    BRI_RST       = 8'd63;
    localparam logic [COLOR_W-1:0]    HUE_RST       = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME = 2'd0,
        REG_MOVE_TIME = 2'd1,
        REG_TARGET_SAT = 2'd2,
        REG_TARGET_BRI = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CH_HUE = 2'd0,
        CH_SAT = 2'd1,
        CH_BRI = 2'd2
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIMER,
        ST_DECIDE,
        ST_START,
        ST_WAIT,
        ST_OUT
    } main_state_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_DIV,
        LS_DONE
    } lerp_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/hsv_xf_lerp.sv
// shared interpolation unit: one multiply, then a bit-serial restoring divide
`default_nettype none
module hsv_xf_lerp
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [hsv_xf_pkg::COLOR_W-1:0]     mag,
    input  wire logic [hsv_xf_pkg::CFG_TIME_W-1:0]  t,
    input  wire logic [hsv_xf_pkg::CFG_TIME_W-1:0]  span,
    output logic                                    done,
    output logic [hsv_xf_pkg::COLOR_W-1:0]          quot
);

    hsv_xf_pkg::lerp_state_t state_reg;
    hsv_xf_pkg::lerp_state_t state_next;

    logic [hsv_xf_pkg::CFG_TIME_W-1:0] rem_reg;
    logic [hsv_xf_pkg::COLOR_W-1:0]    lo_reg;
    logic [2:0]                        cnt_reg;
    logic [hsv_xf_pkg::PROD_W-1:0]     prod;
    logic [hsv_xf_pkg::CFG_TIME_W:0]   shifted;
    logic [hsv_xf_pkg::CFG_TIME_W:0]   trial;
    logic                              qbit;

    assign prod    = hsv_xf_pkg::PROD_W'(mag) * hsv_xf_pkg::PROD_W'(t);
    assign shifted = {rem_reg, lo_reg[hsv_xf_pkg::COLOR_W-1]};
    assign trial   = shifted - {1'b0, span};
    assign qbit    = !trial[hsv_xf_pkg::CFG_TIME_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsv_xf_pkg::LS_IDLE:
            begin
                if (start)
                begin
                    state_next = hsv_xf_pkg::LS_DIV;
                end
            end
            hsv_xf_pkg::LS_DIV:
            begin
                if (cnt_reg == 3'd7)
                begin
                    state_next = hsv_xf_pkg::LS_DONE;
                end
            end
            hsv_xf_pkg::LS_DONE:
            begin
                state_next = hsv_xf_pkg::LS_IDLE;
            end
            default:
            begin
                state_next = hsv_xf_pkg::LS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        done = 1'b0;
        quot = lo_reg;
        case (state_reg)
            hsv_xf_pkg::LS_DONE:
            begin
                done = 1'b1;
                // zero fade time gives a zero fraction
                if (span == '0)
                begin
                    quot = '0;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsv_xf_pkg::LS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hsv_xf_pkg::LS_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == hsv_xf_pkg::LS_DIV)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // product high part is below span, so eight quotient bits suffice
    always_ff @(posedge clk)
    begin
        if (state_reg == hsv_xf_pkg::LS_IDLE && start)
        begin
            rem_reg <= prod[hsv_xf_pkg::PROD_W-1:hsv_xf_pkg::COLOR_W];
            lo_reg  <= prod[hsv_xf_pkg::COLOR_W-1:0];
        end
        else if (state_reg == hsv_xf_pkg::LS_DIV)
        begin
            rem_reg <= qbit ? trial[hsv_xf_pkg::CFG_TIME_W-1:0]
                            : shifted[hsv_xf_pkg::CFG_TIME_W-1:0];
            lo_reg  <= {lo_reg[hsv_xf_pkg::COLOR_W-2:0], qbit};
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/hsv_hold_and_crossfade.sv
// top level: hold and crossfade sequencer for an hsv color
//
// input stream s_*: one transaction per time step, carrying the elapsed
// milliseconds and a random hue; output stream m_*: exactly one color
// transaction per input transaction, in order. configuration is a plain
// write port (cfg_we, cfg_index, cfg_data) used while the block is idle;
// the user must keep to this, the block itself does not enforce it. an
// item in hold, or one that ends a fade, passes from accept through the
// timer and decide states to the output register; an item inside a fade
// also waits for the shared interpolation unit, which runs a multiply,
// eight one-bit divide steps and a result step for each of hue, saturation
// and brightness in turn. one item is processed at a time; a new item is
// taken while the previous result still waits in the output register.
// if the receiver stalls, the finished result waits in the sequencer until
// the output register is free, and no new item is taken meanwhile.
// reset puts the block in hold with hue 0, saturation 255, brightness 63,
// a zero timer, and the configuration registers at their defaults.
`default_nettype none
module hsv_hold_and_crossfade
#(
    parameter int TIME_BITS = hsv_xf_pkg::TIME_BITS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // elapsed_ms, random_hue, zero fill
    input  wire logic [hsv_xf_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // out_hue, out_saturation, out_brightness, is_moving, zero fill
    output logic [hsv_xf_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [hsv_xf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hsv_xf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = (TIME_BITS > hsv_xf_pkg::CFG_TIME_W) ? TIME_BITS
                                                             : hsv_xf_pkg::CFG_TIME_W;
    localparam int SW = ((TIME_BITS > hsv_xf_pkg::ELAPSED_W) ? TIME_BITS
                                                             : hsv_xf_pkg::ELAPSED_W) + 1;
    localparam int CLR = hsv_xf_pkg::COLOR_W;

    hsv_xf_pkg::main_state_t state_reg;
    hsv_xf_pkg::main_state_t state_next;
    hsv_xf_pkg::chan_t       ch_reg;

    logic [hsv_xf_pkg::CFG_TIME_W-1:0] hold_time_reg;
    logic [hsv_xf_pkg::CFG_TIME_W-1:0] move_time_reg;
    logic [CLR-1:0]                    target_sat_reg;
    logic [CLR-1:0]                    target_bri_reg;

    logic                              mode_reg;
    logic [CLR-1:0]                    from_h_reg;
    logic [CLR-1:0]                    from_s_reg;
    logic [CLR-1:0]                    from_v_reg;
    logic [CLR-1:0]                    to_h_reg;
    logic [CLR-1:0]                    to_s_reg;
    logic [CLR-1:0]                    to_v_reg;
    logic [TIME_BITS-1:0]              timer_reg;

    logic [hsv_xf_pkg::ELAPSED_W-1:0]  elapsed_reg;
    logic [CLR-1:0]                    hue_reg;

    logic [CLR-1:0]                    res_h_reg;
    logic [CLR-1:0]                    res_s_reg;
    logic [CLR-1:0]                    res_v_reg;
    logic                              res_mov_reg;

    logic                              m_tvalid_reg;
    logic [hsv_xf_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic                              lerp_start;
    logic                              lerp_done;
    logic [CLR-1:0]                    lerp_quot;
    logic                              out_load;

    logic [SW-1:0]                     tsum;
    logic                              tsat;
    logic [CW-1:0]                     timer_ext;
    logic                              over_hold;
    logic                              over_move;
    logic [CLR-1:0]                    ch_a;
    logic [CLR-1:0]                    ch_b;
    logic signed [9:0]                 diff;
    logic signed [9:0]                 delta;
    logic                              neg;
    logic [9:0]                        mag_full;
    logic [CLR-1:0]                    ch_res;

    assign tsum      = SW'(timer_reg) + SW'(elapsed_reg);
    assign tsat      = (tsum >> TIME_BITS) != '0;
    assign timer_ext = CW'(timer_reg);
    assign over_hold = timer_ext > CW'(hold_time_reg);
    assign over_move = timer_ext > CW'(move_time_reg);

    // channel operands for the interpolation unit
    always_comb
    begin
        case (ch_reg)
            hsv_xf_pkg::CH_HUE:
            begin
                ch_a = from_h_reg;
                ch_b = to_h_reg;
            end
            hsv_xf_pkg::CH_SAT:
            begin
                ch_a = from_s_reg;
                ch_b = to_s_reg;
            end
            default:
            begin
                ch_a = from_v_reg;
                ch_b = to_v_reg;
            end
        endcase
    end

    // hue takes the shorter way round the circle
    always_comb
    begin
        diff  = $signed({2'b00, ch_b}) - $signed({2'b00, ch_a});
        delta = diff;
        if (ch_reg == hsv_xf_pkg::CH_HUE)
        begin
            if (diff > 10'sd127)
            begin
                delta = diff - 10'sd256;
            end
            else if (diff < -10'sd127)
            begin
                delta = diff + 10'sd256;
            end
        end
    end

    assign neg      = delta[9];
    assign mag_full = neg ? 10'(-delta) : 10'(delta);
    assign ch_res   = neg ? (ch_a - lerp_quot) : (ch_a + lerp_quot);

    hsv_xf_lerp u_lerp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .mag   (mag_full[CLR-1:0]),
        .t     (timer_ext[hsv_xf_pkg::CFG_TIME_W-1:0]),
        .span  (move_time_reg),
        .done  (lerp_done),
        .quot  (lerp_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsv_xf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = hsv_xf_pkg::ST_TIMER;
                end
            end
            hsv_xf_pkg::ST_TIMER:
            begin
                state_next = hsv_xf_pkg::ST_DECIDE;
            end
            hsv_xf_pkg::ST_DECIDE:
            begin
                if (mode_reg && !over_move)
                begin
                    state_next = hsv_xf_pkg::ST_START;
                end
                else
                begin
                    state_next = hsv_xf_pkg::ST_OUT;
                end
            end
            hsv_xf_pkg::ST_START:
            begin
                state_next = hsv_xf_pkg::ST_WAIT;
            end
            hsv_xf_pkg::ST_WAIT:
            begin
                if (lerp_done)
                begin
                    state_next = (ch_reg == hsv_xf_pkg::CH_BRI) ? hsv_xf_pkg::ST_OUT
                                                                : hsv_xf_pkg::ST_START;
                end
            end
            hsv_xf_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = hsv_xf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hsv_xf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        lerp_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            hsv_xf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            hsv_xf_pkg::ST_START:
            begin
                lerp_start = 1'b1;
            end
            hsv_xf_pkg::ST_OUT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg  <= hsv_xf_pkg::HOLD_TIME_RST;
            move_time_reg  <= hsv_xf_pkg::MOVE_TIME_RST;
            target_sat_reg <= hsv_xf_pkg::SAT_RST;
            target_bri_reg <= hsv_xf_pkg::BRI_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsv_xf_pkg::REG_HOLD_TIME:  hold_time_reg  <= cfg_data;
                hsv_xf_pkg::REG_MOVE_TIME:  move_time_reg  <= cfg_data;
                hsv_xf_pkg::REG_TARGET_SAT: target_sat_reg <= cfg_data[CLR-1:0];
                hsv_xf_pkg::REG_TARGET_BRI: target_bri_reg <= cfg_data[CLR-1:0];
                default:                    hold_time_reg  <= hold_time_reg;
            endcase
        end
    end

    // sequencer state and color state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hsv_xf_pkg::ST_IDLE;
            ch_reg     <= hsv_xf_pkg::CH_HUE;
            mode_reg   <= 1'b0;
            timer_reg  <= '0;
            from_h_reg <= hsv_xf_pkg::HUE_RST;
            from_s_reg <= hsv_xf_pkg::SAT_RST;
            from_v_reg <= hsv_xf_pkg::BRI_RST;
            to_h_reg   <= hsv_xf_pkg::HUE_RST;
            to_s_reg   <= hsv_xf_pkg::SAT_RST;
            to_v_reg   <= hsv_xf_pkg::BRI_RST;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                hsv_xf_pkg::ST_TIMER:
                begin
                    // saturating timer
                    timer_reg <= tsat ? '1 : tsum[TIME_BITS-1:0];
                    ch_reg    <= hsv_xf_pkg::CH_HUE;
                end
                hsv_xf_pkg::ST_DECIDE:
                begin
                    if (!mode_reg && over_hold)
                    begin
                        from_h_reg <= to_h_reg;
                        from_s_reg <= to_s_reg;
                        from_v_reg <= to_v_reg;
                        to_h_reg   <= hue_reg;
                        to_s_reg   <= target_sat_reg;
                        to_v_reg   <= target_bri_reg;
                        timer_reg  <= '0;
                        mode_reg   <= 1'b1;
                    end
                    else if (mode_reg && over_move)
                    begin
                        timer_reg <= '0;
                        mode_reg  <= 1'b0;
                    end
                end
                hsv_xf_pkg::ST_WAIT:
                begin
                    if (lerp_done)
                    begin
                        case (ch_reg)
                            hsv_xf_pkg::CH_HUE: ch_reg <= hsv_xf_pkg::CH_SAT;
                            hsv_xf_pkg::CH_SAT: ch_reg <= hsv_xf_pkg::CH_BRI;
                            default:            ch_reg <= hsv_xf_pkg::CH_HUE;
                        endcase
                    end
                end
                default:
                begin
                    ch_reg <= ch_reg;
                end
            endcase
        end
    end

    // input capture and result assembly
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            elapsed_reg <= s_tdata[hsv_xf_pkg::ELAPSED_W-1:0];
            hue_reg     <= s_tdata[hsv_xf_pkg::ELAPSED_W +: CLR];
        end
        if (state_reg == hsv_xf_pkg::ST_DECIDE)
        begin
            // old target is shown in every branch that leaves the fade path
            res_h_reg   <= to_h_reg;
            res_s_reg   <= to_s_reg;
            res_v_reg   <= to_v_reg;
            res_mov_reg <= mode_reg ? !over_move : over_hold;
        end
        else if (state_reg == hsv_xf_pkg::ST_WAIT && lerp_done)
        begin
            case (ch_reg)
                hsv_xf_pkg::CH_HUE: res_h_reg <= ch_res;
                hsv_xf_pkg::CH_SAT: res_s_reg <= ch_res;
                default:            res_v_reg <= ch_res;
            endcase
        end
        if (out_load)
        begin
            m_tdata_reg <= hsv_xf_pkg::M_TDATA_W'({res_mov_reg, res_v_reg,
                                                   res_s_reg, res_h_reg});
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
